### hdl/sdes_pkg.sv
// ----------------------------------------------------------------------------
// S-DES package
// Permutation tables, S-boxes and bit-level helpers shared by the cipher
// datapath and its round logic. Table position 0 is the most significant bit.
// ----------------------------------------------------------------------------
package sdes_pkg;

    localparam int KEY_W   = 10;
    localparam int BLOCK_W = 8;
    localparam int HALF_W  = 4;
    localparam int SUBK_W  = 8;

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [HALF_W-1:0]  t_half;
    typedef logic [SUBK_W-1:0]  t_subkey;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    localparam logic [2:0] TAB_IP    [8]  = '{3'd1, 3'd5, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd6};
    localparam logic [2:0] TAB_IPINV [8]  = '{3'd3, 3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd7, 3'd5};
    localparam logic [1:0] TAB_EP    [8]  = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [1:0] TAB_P4    [4]  = '{2'd1, 2'd3, 2'd2, 2'd0};
    localparam logic [3:0] TAB_P10   [10] = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
                                              4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
    localparam logic [3:0] TAB_P8    [8]  = '{4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8};

    // Indexed by {row, col}, row-major.
    localparam logic [1:0] SBOX0 [16] = '{2'd1, 2'd0, 2'd3, 2'd2,
                                          2'd3, 2'd2, 2'd1, 2'd0,
                                          2'd0, 2'd2, 2'd1, 2'd3,
                                          2'd3, 2'd1, 2'd3, 2'd2};
    localparam logic [1:0] SBOX1 [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                          2'd2, 2'd0, 2'd1, 2'd3,
                                          2'd3, 2'd0, 2'd1, 2'd0,
                                          2'd2, 2'd1, 2'd0, 2'd3};

    function automatic t_block f_ip(input t_block v);
        t_block r;
        for (int i = 0; i < 8; i++) begin
            r[3'(7 - i)] = v[3'd7 - TAB_IP[i]];
        end
        return r;
    endfunction

    function automatic t_block f_ipinv(input t_block v);
        t_block r;
        for (int i = 0; i < 8; i++) begin
            r[3'(7 - i)] = v[3'd7 - TAB_IPINV[i]];
        end
        return r;
    endfunction

    function automatic t_subkey f_ep(input t_half v);
        t_subkey r;
        for (int i = 0; i < 8; i++) begin
            r[3'(7 - i)] = v[2'd3 - TAB_EP[i]];
        end
        return r;
    endfunction

    function automatic t_half f_p4(input t_half v);
        t_half r;
        for (int i = 0; i < 4; i++) begin
            r[2'(3 - i)] = v[2'd3 - TAB_P4[i]];
        end
        return r;
    endfunction

    function automatic t_key f_p10(input t_key v);
        t_key r;
        for (int i = 0; i < 10; i++) begin
            r[4'(9 - i)] = v[4'd9 - TAB_P10[i]];
        end
        return r;
    endfunction

    function automatic t_subkey f_p8(input t_key v);
        t_subkey r;
        for (int i = 0; i < 8; i++) begin
            r[3'(7 - i)] = v[4'd9 - TAB_P8[i]];
        end
        return r;
    endfunction

    // rotate each 5-bit half left by one
    function automatic t_key f_rot_halves(input t_key v);
        return {v[8:5], v[9], v[3:0], v[4]};
    endfunction

    // row from outer bits, column from inner bits
    function automatic logic [1:0] f_sbox0(input t_half x);
        return SBOX0[{x[3], x[0], x[2], x[1]}];
    endfunction

    function automatic logic [1:0] f_sbox1(input t_half x);
        return SBOX1[{x[3], x[0], x[2], x[1]}];
    endfunction

endpackage

### hdl/sdes_round.sv
// ----------------------------------------------------------------------------
// S-DES round function fk
// Left half is XORed with P4(S(EP(right) ^ subkey)); right half passes.
// ----------------------------------------------------------------------------
module sdes_round (
    input  sdes_pkg::t_block  i_blk,
    input  sdes_pkg::t_subkey i_subkey,
    output sdes_pkg::t_block  o_blk
);
    import sdes_pkg::*;

    t_subkey w_exp;
    t_half   w_sbox;
    t_half   w_f;

    always_comb begin
        w_exp  = f_ep(i_blk[3:0]) ^ i_subkey;
        w_sbox = {f_sbox0(w_exp[7:4]), f_sbox1(w_exp[3:0])};
        w_f    = f_p4(w_sbox);
        o_blk  = {i_blk[7:4] ^ w_f, i_blk[3:0]};
    end

endmodule

### hdl/sdes_block_cipher.sv
// ----------------------------------------------------------------------------
// S-DES block cipher
// Encrypts or decrypts one 8-bit block per beat under a 10-bit key.
// ----------------------------------------------------------------------------
// Throughput is one block per clock while the output is not stalled. A block
// passes the input register, then both rounds in one combinational pass into
// the result register. Subkeys K1 and K2 are derived and stored when the
// key is written, so the per-block path holds only the two fk rounds and the
// fixed permutations. Subkeys reset to zero; the key is written through the
// configuration channel, which is always ready; write it only while no
// block is in flight. Bit 7 of a block and bit 9 of the key are the first bits.
// ----------------------------------------------------------------------------
module sdes_block_cipher (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  sdes_pkg::t_key    i_cfg_cipher_key,
    // input blocks
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  sdes_pkg::t_block  i_block_in,
    // result blocks
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sdes_pkg::t_block  o_block_out
);
    import sdes_pkg::*;

    t_subkey r_k1, r_k2;
    t_subkey n_k1, n_k2;
    t_key    w_p10;

    logic    r_in_valid;
    t_op     r_op;
    t_block  r_blk;

    logic    r_out_valid;
    t_block  r_blk_out;
    t_block  n_blk_out;

    logic    w_advance;
    t_subkey w_first, w_second;
    t_block  w_ip, w_rnd1, w_swap, w_rnd2;

    // subkey schedule, evaluated on key writes
    always_comb begin
        w_p10 = f_rot_halves(f_p10(i_cfg_cipher_key));
        n_k1  = f_p8(w_p10);
        n_k2  = f_p8(f_rot_halves(f_rot_halves(w_p10)));
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= '0;
            r_k2 <= '0;
        end else if (i_cfg_valid) begin
            r_k1 <= n_k1;
            r_k2 <= n_k2;
        end
    end

    // move the held block into the result register when it is free or drained
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op  <= t_op'(i_operation);
            r_blk <= i_block_in;
        end
    end

    // decryption applies K2 first
    assign w_first  = (r_op == OP_DECRYPT) ? r_k2 : r_k1;
    assign w_second = (r_op == OP_DECRYPT) ? r_k1 : r_k2;

    assign w_ip   = f_ip(r_blk);
    assign w_swap = {w_rnd1[3:0], w_rnd1[7:4]};

    sdes_round u_round1 (
        .i_blk    (w_ip),
        .i_subkey (w_first),
        .o_blk    (w_rnd1)
    );

    sdes_round u_round2 (
        .i_blk    (w_swap),
        .i_subkey (w_second),
        .o_blk    (w_rnd2)
    );

    assign n_blk_out = f_ipinv(w_rnd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_blk_out <= n_blk_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_block_out = r_blk_out;

endmodule
